// File: design/bcdssd_pkg.sv
// ----------------------------------------------------------------------------
// BCD counter seven-segment driver package
// Shared widths, command codes, transaction types and the segment lookup.
// ----------------------------------------------------------------------------
`default_nettype none

package bcdssd_pkg;

   // Field widths.
   localparam int CMD_W    = 2;
   localparam int NUMBER_W = 16;
   localparam int DIV_W    = 16;
   localparam int CODE_W   = 5;
   localparam int SEG_W    = 8;
   localparam int SEL_W    = 4;

   // Defaults and sizes.
   localparam int NUM_DIGITS_DEFAULT = 4;
   localparam int QUEUE_DEPTH        = 2;
   localparam logic [DIV_W-1:0] DIVIDER_RESET = 16'd5000;

   // Command codes.
   localparam logic [CMD_W-1:0] CMD_TICK = 2'd0;
   localparam logic [CMD_W-1:0] CMD_SET  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_DASH = 2'd2;
   localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;

   // Digit codes with a meaning of their own.
   localparam logic [CODE_W-1:0] CODE_DASH = 5'd16;

   // Segment patterns that are not in the digit table.
   localparam logic [SEG_W-1:0] SEG_BLANK = 8'hFF;

   // Divide by ten: (n * 0xCCCD) >> 19 is exact for every 16-bit n.
   localparam logic [NUMBER_W-1:0] RECIP_TEN   = 16'hCCCD;
   localparam int                  RECIP_SHIFT = 19;

   // One queued command.
   typedef struct packed {
      logic [CMD_W-1:0]    command;
      logic [NUMBER_W-1:0] number;
   } item_type;

   // Write side of the command queue.
   typedef struct packed {
      logic     valid;
      item_type item;
   } q_wr_type;

   // Read side of the command queue.
   typedef struct packed {
      logic     valid;
      item_type item;
   } q_rd_type;

   // Active-low segment byte for a digit code; codes above the dash are blank.
   function automatic logic [SEG_W-1:0] seg_of(input logic [CODE_W-1:0] code);
      logic [SEG_W-1:0] seg;
      unique case (code)
         5'd0:    seg = 8'hC0;
         5'd1:    seg = 8'hF9;
         5'd2:    seg = 8'hA4;
         5'd3:    seg = 8'hB0;
         5'd4:    seg = 8'h99;
         5'd5:    seg = 8'h92;
         5'd6:    seg = 8'h82;
         5'd7:    seg = 8'hF8;
         5'd8:    seg = 8'h80;
         5'd9:    seg = 8'h90;
         5'd10:   seg = 8'h8C;
         5'd11:   seg = 8'hBF;
         5'd12:   seg = 8'hC6;
         5'd13:   seg = 8'hA1;
         5'd14:   seg = 8'h86;
         5'd15:   seg = SEG_BLANK;
         5'd16:   seg = 8'hBF;
         default: seg = SEG_BLANK;
      endcase
      return seg;
   endfunction

   // A digit carries when it is a nonzero multiple of ten.
   function automatic logic is_carry(input logic [CODE_W-1:0] code);
      return (code == 5'd10) || (code == 5'd20) || (code == 5'd30);
   endfunction

endpackage

`default_nettype wire

// File: design/bcdssd_front.sv
// ----------------------------------------------------------------------------
// BCD counter front end
// Accepts request transactions, drops unused commands and pushes the rest.
// ----------------------------------------------------------------------------
`default_nettype none

module bcdssd_front (
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   input  wire logic [bcdssd_pkg::NUMBER_W-1:0]  req_tdata,
   input  wire logic [bcdssd_pkg::CMD_W-1:0]     req_tuser,
   input  wire logic                             q_full,
   output bcdssd_pkg::q_wr_type                  wr
);
   import bcdssd_pkg::*;

   logic accept;

   // A transaction is taken whenever the queue has room.
   assign req_tready = !q_full;
   assign accept     = req_tvalid && !q_full;

   // The unused command has no effect, so it never reaches the queue.
   always_comb begin
      wr.valid        = accept && (req_tuser != CMD_NONE);
      wr.item.command = req_tuser;
      wr.item.number  = req_tdata;
   end

endmodule

`default_nettype wire

// File: design/bcdssd_queue.sv
// ----------------------------------------------------------------------------
// BCD counter command queue
// Short FIFO between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module bcdssd_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire bcdssd_pkg::q_wr_type wr,
   output logic                      full,
   output bcdssd_pkg::q_rd_type      rd,
   input  wire logic                 pop
);
   import bcdssd_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   item_type           mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_in;
   logic [PTR_W:0]     count_ff;
   logic [PTR_W:0]     count_in;
   logic               do_pop;

   assign full     = (count_ff == (PTR_W+1)'(QUEUE_DEPTH));
   assign rd.valid = (count_ff != '0);
   assign rd.item  = mem_ff[rd_ptr_ff];
   assign do_pop   = pop && rd.valid;

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr.valid ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (wr.valid && !do_pop) begin
         count_in = count_ff + (PTR_W+1)'(1);
      end else if (do_pop && !wr.valid) begin
         count_in = count_ff - (PTR_W+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage needs no reset.
   always_ff @(posedge clock) begin
      if (wr.valid) begin
         mem_ff[wr_ptr_ff] <= wr.item;
      end
   end

endmodule

`default_nettype wire

// File: design/bcdssd_back.sv
// ----------------------------------------------------------------------------
// BCD counter back end
// Updates the prescaler and digit codes, converts loaded numbers one decimal
// digit per cycle, and streams one display frame per cycle while the output is ready.
// ----------------------------------------------------------------------------
`default_nettype none

module bcdssd_back #(
   parameter int NUM_DIGITS = bcdssd_pkg::NUM_DIGITS_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_we,
   input  wire logic [bcdssd_pkg::DIV_W-1:0]    csr_wdata,
   input  wire bcdssd_pkg::q_rd_type            rd,
   output logic                                 pop,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   output logic [bcdssd_pkg::SEG_W-1:0]         rsp_segment,
   output logic [bcdssd_pkg::SEL_W-1:0]         rsp_select,
   output logic                                 rsp_last
);
   import bcdssd_pkg::*;

   // Configuration and counter state.
   logic [DIV_W-1:0]    divider_ff;
   logic [DIV_W-1:0]    prescaler_ff;
   logic [DIV_W-1:0]    prescaler_in;
   logic [CODE_W-1:0]   digit_ff [NUM_DIGITS];
   logic [CODE_W-1:0]   digit_in [NUM_DIGITS];

   // Decimal conversion state.
   logic [NUM_DIGITS-1:0] div_tok_ff;
   logic [NUM_DIGITS-1:0] div_tok_in;
   logic [NUMBER_W-1:0]   div_num_ff;
   logic [NUMBER_W-1:0]   div_num_in;

   // Frame emitter state.
   logic [NUM_DIGITS-1:0] emit_tok_ff;
   logic [NUM_DIGITS-1:0] emit_tok_in;
   logic [CODE_W-1:0]     snap_ff [NUM_DIGITS];
   logic [CODE_W-1:0]     snap_in [NUM_DIGITS];

   // Output register.
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic [SEG_W-1:0]    rsp_seg_ff;
   logic [SEG_W-1:0]    rsp_seg_in;
   logic [SEL_W-1:0]    rsp_sel_ff;
   logic [SEL_W-1:0]    rsp_sel_in;
   logic                rsp_last_ff;
   logic                rsp_last_in;

   // Working signals.
   logic                      div_busy;
   logic                      emit_busy;
   logic                      out_load;
   logic                      emit_last_now;
   logic                      is_set;
   logic                      pop_frame;
   logic [DIV_W:0]            tick_next;
   logic                      tick_wrap;
   logic [DIV_W-1:0]          tick_prescaler;
   logic [CODE_W-1:0]         tick_codes [NUM_DIGITS];
   logic [2*NUMBER_W-1:0]     div_prod;
   logic [NUMBER_W-1:0]       div_quot;
   logic [NUMBER_W-1:0]       div_quot_x10;
   logic [3:0]                div_rem;
   logic [NUM_DIGITS+SEL_W-1:0] sel_ext;

   assign div_busy      = |div_tok_ff;
   assign emit_busy     = |emit_tok_ff;
   assign out_load      = !rsp_valid_ff || rsp_tready;
   assign emit_last_now = out_load && emit_tok_ff[NUM_DIGITS-1];
   assign is_set        = (rd.item.command == CMD_SET);

   // A command is taken when no conversion runs and, for a refresh, when the
   // emitter is free or hands out its final frame in this cycle.
   assign pop       = rd.valid && !div_busy && (is_set || !emit_busy || emit_last_now);
   assign pop_frame = pop && !is_set;

   // Prescaler step for a tick.
   assign tick_next      = {1'b0, prescaler_ff} + (DIV_W+1)'(1);
   assign tick_wrap      = (tick_next >= {1'b0, divider_ff});
   assign tick_prescaler = tick_wrap ? '0 : tick_next[DIV_W-1:0];

   // Digit increment with ripple carry; a carry out of the top digit clears all.
   always_comb begin
      for (int k = 0; k < NUM_DIGITS; k++) begin
         tick_codes[k] = digit_ff[k];
      end
      if (tick_wrap) begin
         tick_codes[0] = digit_ff[0] + CODE_W'(1);
      end
      for (int k = 0; k < NUM_DIGITS - 1; k++) begin
         if (is_carry(tick_codes[k])) begin
            tick_codes[k]   = '0;
            tick_codes[k+1] = tick_codes[k+1] + CODE_W'(1);
         end
      end
      if (is_carry(tick_codes[NUM_DIGITS-1])) begin
         for (int k = 0; k < NUM_DIGITS; k++) begin
            tick_codes[k] = '0;
         end
      end
   end

   // One decimal digit per cycle: quotient by reciprocal, remainder by subtract.
   assign div_prod     = (2*NUMBER_W)'(div_num_ff) * (2*NUMBER_W)'(RECIP_TEN);
   assign div_quot     = NUMBER_W'(div_prod >> RECIP_SHIFT);
   assign div_quot_x10 = (div_quot << 3) + (div_quot << 1);
   assign div_rem      = 4'(div_num_ff - div_quot_x10);

   // Counter state update.
   always_comb begin
      prescaler_in = prescaler_ff;
      div_num_in   = div_num_ff;
      div_tok_in   = div_tok_ff;
      for (int k = 0; k < NUM_DIGITS; k++) begin
         digit_in[k] = digit_ff[k];
      end
      if (div_busy) begin
         // Remainders enter at the top and move down, so the first lands in digit 0.
         for (int k = 0; k < NUM_DIGITS; k++) begin
            if (k == NUM_DIGITS - 1) begin
               digit_in[k] = {1'b0, div_rem};
            end else begin
               digit_in[k] = digit_ff[k+1];
            end
         end
         div_num_in = div_quot;
         div_tok_in = div_tok_ff << 1;
      end else if (pop) begin
         unique case (rd.item.command)
            CMD_TICK: begin
               prescaler_in = tick_prescaler;
               for (int k = 0; k < NUM_DIGITS; k++) begin
                  digit_in[k] = tick_codes[k];
               end
            end
            CMD_SET: begin
               div_num_in = rd.item.number;
               div_tok_in = NUM_DIGITS'(1);
            end
            CMD_DASH: begin
               digit_in[0] = CODE_DASH;
            end
            default: begin
            end
         endcase
      end
   end

   // Digit select of the frame being sent, widened before the fixed-width cut.
   assign sel_ext = (NUM_DIGITS+SEL_W)'(emit_tok_ff);

   // Frame emitter and output register.
   always_comb begin
      emit_tok_in  = emit_tok_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_seg_in   = rsp_seg_ff;
      rsp_sel_in   = rsp_sel_ff;
      rsp_last_in  = rsp_last_ff;
      for (int k = 0; k < NUM_DIGITS; k++) begin
         snap_in[k] = snap_ff[k];
      end
      if (out_load) begin
         rsp_valid_in = emit_busy;
         rsp_seg_in   = seg_of(snap_ff[0]);
         rsp_sel_in   = sel_ext[SEL_W-1:0];
         rsp_last_in  = emit_tok_ff[NUM_DIGITS-1];
         emit_tok_in  = emit_tok_ff << 1;
         for (int k = 0; k < NUM_DIGITS - 1; k++) begin
            snap_in[k] = snap_ff[k+1];
         end
      end
      if (pop_frame) begin
         // A new refresh starts from the freshly updated digit codes.
         emit_tok_in = NUM_DIGITS'(1);
         for (int k = 0; k < NUM_DIGITS; k++) begin
            snap_in[k] = digit_in[k];
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         divider_ff   <= DIVIDER_RESET;
         prescaler_ff <= '0;
         div_tok_ff   <= '0;
         emit_tok_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < NUM_DIGITS; k++) begin
            digit_ff[k] <= '0;
         end
      end else begin
         if (csr_we) begin
            divider_ff <= csr_wdata;
         end
         prescaler_ff <= prescaler_in;
         div_tok_ff   <= div_tok_in;
         emit_tok_ff  <= emit_tok_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int k = 0; k < NUM_DIGITS; k++) begin
            digit_ff[k] <= digit_in[k];
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      div_num_ff  <= div_num_in;
      rsp_seg_ff  <= rsp_seg_in;
      rsp_sel_ff  <= rsp_sel_in;
      rsp_last_ff <= rsp_last_in;
      for (int k = 0; k < NUM_DIGITS; k++) begin
         snap_ff[k] <= snap_in[k];
      end
   end

   assign rsp_tvalid  = rsp_valid_ff;
   assign rsp_segment = rsp_seg_ff;
   assign rsp_select  = rsp_sel_ff;
   assign rsp_last    = rsp_last_ff;

`ifndef SYNTHESIS
   // The emitter walks exactly one frame position at a time.
   a_emit_tok_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0(emit_tok_ff))
      else $error("frame token has more than one bit set");

   // The conversion walks exactly one digit position at a time.
   a_div_tok_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0(div_tok_ff))
      else $error("conversion token has more than one bit set");

   // A conversion only starts from a popped set-number command.
   a_div_start: assert property (@(posedge clock) disable iff (reset)
      $rose(div_busy) |-> $past(pop && is_set))
      else $error("conversion started without a set-number command");

   // Carries are always resolved, so no stored digit rests on a nonzero multiple of ten.
   for (genvar g = 0; g < NUM_DIGITS; g++) begin : g_no_carry
      a_no_carry_code: assert property (@(posedge clock) disable iff (reset)
         (digit_ff[g] != 5'd10) && (digit_ff[g] != 5'd20) && (digit_ff[g] != 5'd30))
         else $error("digit code left with an unresolved carry");
   end
`endif

endmodule

`default_nettype wire

// File: design/bcd_counter_seven_segment_driver.sv
// ----------------------------------------------------------------------------
// BCD counter seven-segment driver
// Decimal tick counter that streams multiplexed seven-segment display frames.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake           | Payload
//  req     | in        | req_tvalid/tready   | tdata: number; tuser: command
//  rsp     | out       | rsp_tvalid/tready   | tdata: segment byte, select; tlast
//  csr     | in        | csr_we              | csr_wdata: tick divider
//
//  A tick or dash command yields NUM_DIGITS frames (4 by default), one per cycle
//  while the output is ready; the next such command waits for its final frame.
//  A set-number command steps digit by digit through the shared divide-by-ten
//  step and overlaps frames still being sent; the next refresh waits for it.
//  A two-entry command queue and the output register let each side stall alone.
//  Reset is synchronous and clears the counter, the queue and the output valid.
// ----------------------------------------------------------------------------
`default_nettype none

module bcd_counter_seven_segment_driver #(
   parameter int NUM_DIGITS = bcdssd_pkg::NUM_DIGITS_DEFAULT
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // Request channel.
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   input  wire logic [15:0]                    req_tdata,  // [15:0] number
   input  wire logic [1:0]                     req_tuser,  // [1:0] command
   // Result channel.
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   output logic [15:0]                         rsp_tdata,  // [7:0] segment_pattern,
                                                           // [11:8] digit_select,
                                                           // [15:12] zero
   output logic                                rsp_tlast,
   // Configuration port.
   input  wire logic                           csr_we,
   input  wire logic [15:0]                    csr_wdata   // tick_divider
);
   import bcdssd_pkg::*;

   q_wr_type          q_wr;
   q_rd_type          q_rd;
   logic              q_full;
   logic              q_pop;
   logic [SEG_W-1:0]  rsp_segment;
   logic [SEL_W-1:0]  rsp_select;

   // Accept and classify incoming transactions.
   bcdssd_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_full     (q_full),
      .wr         (q_wr)
   );

   // Decouple the front end from the back end.
   bcdssd_queue u_queue (
      .clock (clock),
      .reset (reset),
      .wr    (q_wr),
      .full  (q_full),
      .rd    (q_rd),
      .pop   (q_pop)
   );

   // Counter update, conversion and frame output.
   bcdssd_back #(
      .NUM_DIGITS (NUM_DIGITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .rd          (q_rd),
      .pop         (q_pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_segment (rsp_segment),
      .rsp_select  (rsp_select),
      .rsp_last    (rsp_tlast)
   );

   // Pack the result fields, lowest field first, padded to whole bytes.
   assign rsp_tdata = {4'b0000, rsp_select, rsp_segment};

endmodule

`default_nettype wire
